// ===== rtl/core/ddict_pkg.sv =====
// ----------------------------------------------------------------------------
// ddict_pkg : shared definitions of the dense identifier dictionary
// Table sizing, key and field types, controller states, RAM write port.
// ----------------------------------------------------------------------------
`default_nettype none

package ddict_pkg;

	localparam int TABLE_DEPTH    = 256;
	localparam int POSITION_WIDTH = 12;

	localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);

	// fixed field widths of the channels
	localparam int BASE_W  = 4;
	localparam int POS_W   = 12;
	localparam int INDEX_W = 8;

	localparam int KEY_W = BASE_W + POSITION_WIDTH;

	localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(TABLE_DEPTH);

	typedef logic [BASE_W-1:0]  base_t;
	typedef logic [POS_W-1:0]   pos_t;
	typedef logic [INDEX_W-1:0] index_t;
	typedef logic [KEY_W-1:0]   key_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef enum logic {
		MODE_LOOKUP = 1'b0,
		MODE_CLEAR  = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} ddict_state_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
		key_t  data;
	} ddict_wr_t;

	// key is base over the low POSITION_WIDTH bits of position
	function automatic key_t make_key(base_t b, pos_t p);
		return {b, POSITION_WIDTH'(p)};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ddict_if.sv =====
// ----------------------------------------------------------------------------
// ddict_req_if / ddict_rsp_if : valid/ready channels of the dictionary
// Request carries mode and key; response carries identifier and flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddict_req_if;
	import ddict_pkg::*;

	logic  valid;
	logic  ready;
	logic  mode;
	base_t base;
	pos_t  position;

	modport source (output valid, output mode, output base, output position, input ready);
	modport sink   (input valid, input mode, input base, input position, output ready);
endinterface

interface ddict_rsp_if;
	import ddict_pkg::*;

	logic   valid;
	logic   ready;
	index_t index;
	logic   is_new;
	logic   full_res;

	modport source (output valid, output index, output is_new, output full_res, input ready);
	modport sink   (input valid, input index, input is_new, input full_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ddict_store.sv =====
// ----------------------------------------------------------------------------
// ddict_store : key memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ddict_store (
	input  wire                  clk,
	input  ddict_pkg::ddict_wr_t wr,
	input  wire                  rd_en,
	input  ddict_pkg::addr_t     rd_addr,
	output ddict_pkg::key_t      rd_data
);
	import ddict_pkg::*;

	key_t mem_q [TABLE_DEPTH];
	key_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/core/dense_id_dictionary.sv =====
// ----------------------------------------------------------------------------
// dense_id_dictionary : insert-or-lookup of (base, position) keys
// Hands out dense identifiers in order of first arrival.
// ----------------------------------------------------------------------------
// Usage
//  req (valid/ready): mode, base, position. Mode lookup searches the table;
//    a known key returns its identifier, a new key is stored under the next
//    identifier (is_new set). Mode clear empties the table, result all zero.
//  rsp (valid/ready): index, is_new, full_res. When the table is full a new
//    key is dropped and the result carries full_res with index 0.
//  One transaction in, exactly one out, in order.
// Timing
//  Keys sit in a RAM with registered read data, scanned one entry per cycle.
//  A clear goes straight to the result; a lookup reads stored entries from
//  index 0 until a hit or the last stored key, then stores a new key if room.
//  One transaction in work at a time; req.ready is high only while idle, from
//  the cycle after the load.
// Reset and stall
//  arst_n empties the table (count to zero) and drops any pending result;
//  RAM contents are not cleared, only entries below the count are read.
//  A stalled rsp keeps its result; the next request is taken meanwhile and
//  its result waits in the controller until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module dense_id_dictionary (
	input wire          clk,
	input wire          arst_n,
	ddict_req_if.sink   req,
	ddict_rsp_if.source rsp
);
	import ddict_pkg::*;

	ddict_state_t state_q, state_d;

	count_t count_q;     // stored keys
	count_t issue_q;     // next RAM address to read
	key_t   key_q;       // key under search
	logic   rd_vld_s1;   // read data valid this cycle
	addr_t  rd_addr_s1;  // address of that data

	index_t res_index_q;
	logic   res_new_q;
	logic   res_full_q;

	logic   out_vld_q;
	index_t out_index_q;
	logic   out_new_q;
	logic   out_full_q;

	logic      rd_en;
	key_t      rd_data;
	ddict_wr_t wr;
	logic      scan_hit;
	logic      scan_miss;
	logic      room;
	logic      out_load;

	ddict_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (issue_q[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	assign room = (count_q < DEPTH_CNT);

	// controller: next state and strobes
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		rd_en     = 1'b0;
		scan_hit  = 1'b0;
		scan_miss = 1'b0;
		out_load  = 1'b0;
		wr        = '0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = (req.mode == MODE_CLEAR) ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en     = (issue_q != count_q);
				scan_hit  = rd_vld_s1 && (rd_data == key_q);
				scan_miss = !rd_vld_s1 && (issue_q == count_q);
				if (scan_hit || scan_miss) begin
					state_d = ST_DONE;
				end
				// miss with room: append at the end of the table
				if (scan_miss && room) begin
					wr.en   = 1'b1;
					wr.addr = count_q[ADDR_W-1:0];
					wr.data = key_q;
				end
			end
			ST_DONE: begin
				if (!out_vld_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// scan control and table count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			issue_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				issue_q   <= '0;
				rd_vld_s1 <= 1'b0;
				if (req.mode == MODE_CLEAR) begin
					count_q <= '0;
				end
			end else if (state_q == ST_SCAN) begin
				rd_vld_s1 <= rd_en;
				if (rd_en) begin
					issue_q <= issue_q + COUNT_W'(1);
				end
				if (scan_miss && room) begin
					count_q <= count_q + COUNT_W'(1);
				end
			end
		end
	end

	// key and pending result (payload, no reset)
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			key_q       <= make_key(req.base, req.position);
			res_index_q <= '0;
			res_new_q   <= 1'b0;
			res_full_q  <= 1'b0;
		end else if (state_q == ST_SCAN) begin
			rd_addr_s1 <= issue_q[ADDR_W-1:0];
			if (scan_hit) begin
				res_index_q <= INDEX_W'(rd_addr_s1);
			end else if (scan_miss && room) begin
				res_index_q <= INDEX_W'(count_q[ADDR_W-1:0]);
				res_new_q   <= 1'b1;
			end else if (scan_miss) begin
				res_full_q  <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_index_q <= res_index_q;
			out_new_q   <= res_new_q;
			out_full_q  <= res_full_q;
		end
	end

	assign rsp.valid    = out_vld_q;
	assign rsp.index    = out_index_q;
	assign rsp.is_new   = out_new_q;
	assign rsp.full_res = out_full_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CNT)
		else $error("entry count above table depth");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.mode == MODE_CLEAR) |=> (count_q == '0))
		else $error("clear did not empty table");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && scan_miss && room)
		|=> (count_q == $past(count_q) + COUNT_W'(1)))
		else $error("insert did not advance count");

	a_full_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.full_res) |-> (!rsp.is_new && rsp.index == '0))
		else $error("full result with identifier or new flag");

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> room)
		else $error("write into full table");

endmodule

`default_nettype wire
